[sv/dlcrc_pkg.sv]
// Shared constants and CRC-16 update functions for the dual-lane word checksum.
`default_nettype none

package dlcrc_pkg;

    // Field widths.
    localparam int WORD_W = 16;
    localparam int CRC_W  = 16;
    localparam int SUM_W  = 2 * CRC_W;

    // Non-reflected CRC-16 polynomial and output inversion mask.
    localparam logic [CRC_W-1:0] CRC_POLY   = 16'h8005;
    localparam logic [SUM_W-1:0] OUT_INVERT = 32'hFFFF_FFFF;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SUM_W-1:0]  sum_t;

    // Absorb one byte, MSB first: eight shift-and-reduce steps.
    function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // Absorb one word, high byte first, then low byte.
    function automatic crc_t crc_word(input crc_t crc, input word_t w);
        crc_t c;
        c = crc_byte(crc, w[15:8]);
        return crc_byte(c, w[7:0]);
    endfunction

endpackage

`default_nettype wire

[sv/dlcrc_if.sv]
// Valid/ready channel interfaces for words, checksums and the init value register.
`default_nettype none

interface dlcrc_word_if
    import dlcrc_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t data_word;
    logic  last;

    modport source (output valid, output data_word, output last, input ready);
    modport sink   (input valid, input data_word, input last, output ready);
endinterface

interface dlcrc_sum_if
    import dlcrc_pkg::*;
();
    logic valid;
    logic ready;
    sum_t checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

interface dlcrc_cfg_if
    import dlcrc_pkg::*;
();
    logic valid;
    logic ready;
    crc_t init_value;

    modport source (output valid, output init_value, input ready);
    modport sink   (input valid, input init_value, output ready);
endinterface

`default_nettype wire

[sv/dual_lane_crc16_word_checksum.sv]
// A word is registered at acceptance and absorbed into its lane when it advances;
// the checksum of a last word is loaded into the result register as that word is absorbed.
// Throughput: one word per cycle, set by the two-byte CRC update between the input
// register and the lane registers; a last word waits only while an older checksum is unread.
// Reset: rst_n clears all control state, sets init_value to 0 and loads both lanes with 0.
// A write of init_value also reloads both lanes and points the next word at the even lane.
`default_nettype none

module dual_lane_crc16_word_checksum
    import dlcrc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlcrc_word_if.sink  data,
    dlcrc_sum_if.source result,
    dlcrc_cfg_if.sink   cfg
);

    // Input register.
    logic  in_valid_reg;
    logic  in_valid_next;
    word_t data_word_reg;
    logic  last_reg;

    // Lane state.
    crc_t  init_value_reg;
    crc_t  even_crc_reg;
    crc_t  even_crc_next;
    crc_t  odd_crc_reg;
    crc_t  odd_crc_next;
    logic  parity_reg;
    logic  parity_next;

    // Result register.
    logic  out_valid_reg;
    logic  out_valid_next;
    sum_t  checksum_reg;
    sum_t  checksum_next;

    logic  advance;
    logic  data_take;
    crc_t  lane_crc;
    crc_t  lane_updated;

    // A held word moves on unless it is a last word blocked by an unread checksum.
    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign data.ready = !in_valid_reg || advance;
    assign data_take = data.valid && data.ready;
    assign cfg.ready = 1'b1;

    assign result.valid    = out_valid_reg;
    assign result.checksum = checksum_reg;

    // CRC update of the lane selected by the word position.
    assign lane_crc     = parity_reg ? odd_crc_reg : even_crc_reg;
    assign lane_updated = crc_word(lane_crc, data_word_reg);

    // Next lane state, parity and result.
    always_comb
    begin
        even_crc_next  = even_crc_reg;
        odd_crc_next   = odd_crc_reg;
        parity_next    = parity_reg;
        checksum_next  = checksum_reg;
        out_valid_next = out_valid_reg && !result.ready;
        in_valid_next  = data_take || (in_valid_reg && !advance);

        if (advance)
        begin
            if (parity_reg)
                odd_crc_next = lane_updated;
            else
                even_crc_next = lane_updated;
            parity_next = !parity_reg;

            if (last_reg)
            begin
                checksum_next  = (parity_reg ? {lane_updated, even_crc_reg}
                                             : {odd_crc_reg, lane_updated}) ^ OUT_INVERT;
                out_valid_next = 1'b1;
                even_crc_next  = init_value_reg;
                odd_crc_next   = init_value_reg;
                parity_next    = 1'b0;
            end
        end

        // A register write restarts the stream from the new value.
        if (cfg.valid)
        begin
            even_crc_next = cfg.init_value;
            odd_crc_next  = cfg.init_value;
            parity_next   = 1'b0;
        end
    end

    // Control and lane registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            parity_reg     <= 1'b0;
            init_value_reg <= '0;
            even_crc_reg   <= '0;
            odd_crc_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            parity_reg    <= parity_next;
            even_crc_reg  <= even_crc_next;
            odd_crc_reg   <= odd_crc_next;
            if (cfg.valid)
                init_value_reg <= cfg.init_value;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            data_word_reg <= data.data_word;
            last_reg      <= data.last;
        end
        checksum_reg <= checksum_next;
    end

endmodule

`default_nettype wire
